>>> design/ptsd_pkg.sv
// ----------------------------------------------------------------------------
// ptsd_pkg
// shared constants and types of the priority task scheduler with delays
// ----------------------------------------------------------------------------
package ptsd_pkg;

  localparam int unsigned TASK_SLOTS  = 16;
  localparam int unsigned DELAY_WIDTH = 32;

  localparam int unsigned SLOT_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  localparam int unsigned MODE_W      = 2;
  localparam int unsigned INDEX_W     = 4;
  localparam int unsigned TICKS_W     = 32;
  localparam int unsigned NEXT_W      = 4;
  localparam int unsigned MASK_W      = 16;
  localparam int unsigned TOTAL_W     = 32;

  localparam logic [TICKS_W:0] DELAY_MAX = (33'd1 << DELAY_WIDTH) - 33'd1;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK   = 2'd0,
    MODE_CREATE = 2'd1,
    MODE_DELAY  = 2'd2,
    MODE_SCHED  = 2'd3
  } mode_e;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
  } pick_t;

endpackage

>>> design/ptsd_prio_enc.sv
// ----------------------------------------------------------------------------
// ptsd_prio_enc
// finds the lowest-index ready slot; lower index means higher priority
// ----------------------------------------------------------------------------
module ptsd_prio_enc (
  input  logic [ptsd_pkg::TASK_SLOTS-1:0] ready_i,
  output ptsd_pkg::pick_t                 pick_o
);
  import ptsd_pkg::*;

  always_comb begin
    pick_o.found = 1'b0;
    pick_o.slot  = '0;
    for (int s = TASK_SLOTS - 1; s >= 0; s--) begin
      if (ready_i[s]) begin
        pick_o.found = 1'b1;
        pick_o.slot  = SLOT_W'(s);
      end
    end
  end

endmodule

>>> design/priority_task_scheduler_with_delays_core.sv
// ----------------------------------------------------------------------------
// priority_task_scheduler_with_delays_core
// fixed-priority task scheduler with per-slot tick delays
// ----------------------------------------------------------------------------
// Takes one request per clock cycle unless the output stalls, and gives its
// result in the next cycle from an output register. A new request is accepted
// whenever that register is empty or is being taken in the same cycle, so the
// sustained rate is one request per cycle. All slots are updated in parallel and,
// on DELAY or SCHED, a priority encoder on the new ready bits picks the next task.
module priority_task_scheduler_with_delays_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ptsd_pkg::MODE_W-1:0]     mode_i,
  input  logic [ptsd_pkg::INDEX_W-1:0]    task_index_i,
  input  logic [ptsd_pkg::TICKS_W-1:0]    delay_ticks_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ptsd_pkg::NEXT_W-1:0]     next_task_o,
  output logic                            task_found_o,
  output logic [ptsd_pkg::MASK_W-1:0]     ready_mask_o,
  output logic [ptsd_pkg::TOTAL_W-1:0]    tick_total_o
);
  import ptsd_pkg::*;

  logic [TASK_SLOTS-1:0]  present_q, present_d;
  logic [TASK_SLOTS-1:0]  delayed_q, delayed_d;
  logic [DELAY_WIDTH-1:0] remain_q [TASK_SLOTS];
  logic [DELAY_WIDTH-1:0] remain_d [TASK_SLOTS];
  logic [SLOT_W-1:0]      cur_q, cur_d;
  logic [TOTAL_W-1:0]     tick_q, tick_d;

  logic                   out_valid_q;
  logic [NEXT_W-1:0]      next_task_q;
  logic                   task_found_q;
  logic [MASK_W-1:0]      ready_mask_q;

  logic                   accept;
  logic                   resched;
  logic                   idx_ok;
  logic [SLOT_W-1:0]      idx;
  logic [SLOT_W+INDEX_W-1:0] idx_ext;
  logic [DELAY_WIDTH-1:0] sat_ticks;
  logic [TASK_SLOTS-1:0]  ready_d;
  logic [TASK_SLOTS+MASK_W-1:0] mask_ext;
  logic [SLOT_W+NEXT_W-1:0]     next_ext;
  pick_t                  pick;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign idx_ext   = {{SLOT_W{1'b0}}, task_index_i};
  assign idx       = idx_ext[SLOT_W-1:0];
  assign idx_ok    = 32'(task_index_i) < 32'(TASK_SLOTS);
  assign sat_ticks = ({1'b0, delay_ticks_i} > DELAY_MAX) ? DELAY_MAX[DELAY_WIDTH-1:0]
                                                          : delay_ticks_i[DELAY_WIDTH-1:0];

  always_comb begin
    present_d = present_q;
    delayed_d = delayed_q;
    remain_d  = remain_q;
    tick_d    = tick_q;
    resched   = 1'b0;
    unique case (mode_e'(mode_i))
      MODE_TICK: begin
        tick_d = tick_q + TOTAL_W'(1);
        for (int s = 0; s < TASK_SLOTS; s++) begin
          if (present_q[s] && delayed_q[s]) begin
            if (remain_q[s] <= DELAY_WIDTH'(1)) begin
              remain_d[s]  = '0;
              delayed_d[s] = 1'b0;
            end else begin
              remain_d[s] = remain_q[s] - DELAY_WIDTH'(1);
            end
          end
        end
      end
      MODE_CREATE: begin
        if (idx_ok) begin
          present_d[idx] = 1'b1;
          delayed_d[idx] = 1'b0;
          remain_d[idx]  = '0;
        end
      end
      MODE_DELAY: begin
        resched = 1'b1;
        if (present_q[cur_q] && (sat_ticks != '0)) begin
          delayed_d[cur_q] = 1'b1;
          remain_d[cur_q]  = sat_ticks;
        end
      end
      MODE_SCHED: begin
        resched = 1'b1;
      end
      default: begin
        resched = 1'b0;
      end
    endcase
  end

  assign ready_d = present_d & ~delayed_d;

  ptsd_prio_enc u_prio_enc (
    .ready_i (ready_d),
    .pick_o  (pick)
  );

  assign cur_d    = (resched && pick.found) ? pick.slot : cur_q;
  assign mask_ext = {{MASK_W{1'b0}}, ready_d};
  assign next_ext = {{NEXT_W{1'b0}}, cur_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q   <= '0;
      delayed_q   <= '0;
      cur_q       <= '0;
      tick_q      <= '0;
      out_valid_q <= 1'b0;
      for (int s = 0; s < TASK_SLOTS; s++) begin
        remain_q[s] <= '0;
      end
    end else begin
      if (accept) begin
        present_q   <= present_d;
        delayed_q   <= delayed_d;
        remain_q    <= remain_d;
        cur_q       <= cur_d;
        tick_q      <= tick_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      next_task_q  <= next_ext[NEXT_W-1:0];
      task_found_q <= resched && pick.found;
      ready_mask_q <= mask_ext[MASK_W-1:0];
    end
  end

  logic [TOTAL_W-1:0] tick_out_q;
  always_ff @(posedge clk_i) begin
    if (accept) begin
      tick_out_q <= tick_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign next_task_o  = next_task_q;
  assign task_found_o = task_found_q;
  assign ready_mask_o = ready_mask_q;
  assign tick_total_o = tick_out_q;

endmodule
